// ===== rtl/srdz_pkg.sv =====
// Shared constants for the stick radial dead zone block.
// No dependencies; used by the top level and its port checker.
package srdz_pkg;

    localparam int DATA_W = 16;
    localparam int DEAD_W = 15;

    localparam logic [DEAD_W-1:0] DEAD_RESET = 15'd9830;

    // Most negative output code; the block never drives it.
    localparam logic [DATA_W-1:0] OUT_NEG_LIMIT = 16'h8000;

endpackage

// ===== rtl/stick_radial_dead_zone.sv =====
// Scaled radial dead zone: pipelined magnitude, rescale and per-axis division.
// Depends on srdz_pkg (widths, dead zone reset value).
// Throughput: one word per cycle while s_tready is high; square root and both dividers retire one bit per stage.
// The output register plus a skid stage keep s_tready up while one result waits.
// Reset (aresetn low, synchronous) empties the pipeline and loads dead_zone_level = 9830.
module stick_radial_dead_zone #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [srdz_pkg::DEAD_W-1:0]     cfg_wdata,   // dead_zone_level
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*srdz_pkg::DATA_W-1:0]   s_tdata,     // stick_x, stick_y
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*srdz_pkg::DATA_W-1:0]   m_tdata,     // out_x, out_y
    output logic [0:0]                      m_tuser      // in_dead_zone
);

    localparam int W  = SAMPLE_BITS;
    localparam int Q  = W - 1;
    localparam int NW = 2 * W;
    localparam int DW = srdz_pkg::DATA_W;
    localparam int CW = (W > srdz_pkg::DEAD_W) ? W : srdz_pkg::DEAD_W;
    localparam logic [W-1:0] FULL = {1'b0, {Q{1'b1}}};

    typedef struct packed {
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic         xn;
        logic         yn;
    } side_t;

    typedef struct packed {
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic [W-1:0] mag;
        logic         xn;
        logic         yn;
        logic         dz;
        logic         zero;
        logic         sat;
        logic         satx;
        logic         saty;
    } ctl_t;

    logic [srdz_pkg::DEAD_W-1:0] dead_reg;

    logic en;
    logic skid_v_reg;
    logic m_v_reg;
    logic [DW-1:0] m_x_reg, m_y_reg, skid_x_reg, skid_y_reg;
    logic m_dz_reg, skid_dz_reg;

    // stage A: sign and magnitude
    logic [W-1:0] xs, ys;
    logic a_v_reg;
    side_t a_side_reg;
    // stage B: squares
    logic b_v_reg;
    logic [NW-1:0] b_sqx_reg, b_sqy_reg;
    side_t b_side_reg;
    // square root, index 0 holds the sum
    logic          sq_v_reg    [0:W];
    logic [NW-1:0] sq_n_reg    [0:W];
    logic [NW-1:0] sq_res_reg  [0:W];
    side_t         sq_side_reg [0:W];
    logic [NW-1:0] sq_n_next   [1:W];
    logic [NW-1:0] sq_res_next [1:W];
    // stage D: dead zone compare
    logic d_v_reg;
    logic [W-1:0] mag;
    logic [W-1:0] d_diff_reg;
    logic [Q-1:0] d_den_reg;
    ctl_t d_ctl_reg;
    // scale divider, index 0 holds the numerator
    logic          dv_v_reg   [0:Q];
    logic [NW-1:0] dv_r_reg   [0:Q];
    logic [Q-1:0]  dv_q_reg   [0:Q];
    logic [Q-1:0]  dv_den_reg [0:Q];
    ctl_t          dv_ctl_reg [0:Q];
    logic [NW-1:0] dv_r_next  [1:Q];
    logic [Q-1:0]  dv_q_next  [1:Q];
    // stage F: scaled magnitude
    logic f_v_reg;
    logic [Q-1:0] f_scaled_reg;
    ctl_t f_ctl_reg;
    // stage G: axis products
    logic g_v_reg;
    logic [NW-1:0] g_px_reg, g_py_reg;
    ctl_t g_ctl_reg;
    ctl_t g_ctl_sat;
    // axis dividers, index 0 holds the products
    logic          xd_v_reg   [0:Q];
    logic [NW-1:0] xd_rx_reg  [0:Q];
    logic [NW-1:0] xd_ry_reg  [0:Q];
    logic [Q-1:0]  xd_qx_reg  [0:Q];
    logic [Q-1:0]  xd_qy_reg  [0:Q];
    ctl_t          xd_ctl_reg [0:Q];
    logic [NW-1:0] xd_rx_next [1:Q];
    logic [NW-1:0] xd_ry_next [1:Q];
    logic [Q-1:0]  xd_qx_next [1:Q];
    logic [Q-1:0]  xd_qy_next [1:Q];
    // stage I: signed outputs
    logic i_v_reg;
    logic [DW-1:0] i_x_reg, i_y_reg;
    logic i_dz_reg;
    logic [Q-1:0] fin_x, fin_y;
    logic [DW-1:0] ext_x, ext_y;

    function automatic logic [NW-1:0] sq_bit(input int k);
        return NW'(1) << (2 * (W - 1 - k));
    endfunction

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign m_tvalid = m_v_reg;
    assign m_tdata  = {m_y_reg, m_x_reg};
    assign m_tuser  = m_dz_reg;

    assign xs  = s_tdata[W-1:0];
    assign ys  = s_tdata[DW+W-1:DW];
    assign mag = sq_res_reg[W][W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_reg <= srdz_pkg::DEAD_RESET;
        end else if (cfg_we) begin
            dead_reg <= cfg_wdata;
        end
    end

    always_comb begin
        for (int k = 0; k < W; k++) begin
            sq_n_next[k+1]   = sq_n_reg[k];
            sq_res_next[k+1] = sq_res_reg[k] >> 1;
            if (sq_n_reg[k] >= sq_res_reg[k] + sq_bit(k)) begin
                sq_n_next[k+1]   = sq_n_reg[k] - (sq_res_reg[k] + sq_bit(k));
                sq_res_next[k+1] = (sq_res_reg[k] >> 1) + sq_bit(k);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < Q; j++) begin
            dv_r_next[j+1] = dv_r_reg[j];
            dv_q_next[j+1] = dv_q_reg[j];
            if (dv_r_reg[j] >= (NW'(dv_den_reg[j]) << (Q - 1 - j))) begin
                dv_r_next[j+1] = dv_r_reg[j] - (NW'(dv_den_reg[j]) << (Q - 1 - j));
                dv_q_next[j+1] = dv_q_reg[j] | (Q'(1) << (Q - 1 - j));
            end
        end
    end

    // quotient above FULL iff product >= mag * 2^Q
    always_comb begin
        g_ctl_sat      = g_ctl_reg;
        g_ctl_sat.satx = g_px_reg >= (NW'(g_ctl_reg.mag) << Q);
        g_ctl_sat.saty = g_py_reg >= (NW'(g_ctl_reg.mag) << Q);
    end

    always_comb begin
        for (int j = 0; j < Q; j++) begin
            xd_rx_next[j+1] = xd_rx_reg[j];
            xd_qx_next[j+1] = xd_qx_reg[j];
            xd_ry_next[j+1] = xd_ry_reg[j];
            xd_qy_next[j+1] = xd_qy_reg[j];
            if (xd_rx_reg[j] >= (NW'(xd_ctl_reg[j].mag) << (Q - 1 - j))) begin
                xd_rx_next[j+1] = xd_rx_reg[j] - (NW'(xd_ctl_reg[j].mag) << (Q - 1 - j));
                xd_qx_next[j+1] = xd_qx_reg[j] | (Q'(1) << (Q - 1 - j));
            end
            if (xd_ry_reg[j] >= (NW'(xd_ctl_reg[j].mag) << (Q - 1 - j))) begin
                xd_ry_next[j+1] = xd_ry_reg[j] - (NW'(xd_ctl_reg[j].mag) << (Q - 1 - j));
                xd_qy_next[j+1] = xd_qy_reg[j] | (Q'(1) << (Q - 1 - j));
            end
        end
    end

    always_comb begin
        fin_x = xd_ctl_reg[Q].satx ? FULL[Q-1:0] : xd_qx_reg[Q];
        fin_y = xd_ctl_reg[Q].saty ? FULL[Q-1:0] : xd_qy_reg[Q];
        ext_x = DW'(fin_x);
        ext_y = DW'(fin_y);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            for (int k = 0; k <= W; k++) begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= Q; j++) begin
                dv_v_reg[j] <= 1'b0;
                xd_v_reg[j] <= 1'b0;
            end
        end else if (en) begin
            a_v_reg     <= s_tvalid;
            b_v_reg     <= a_v_reg;
            sq_v_reg[0] <= b_v_reg;
            for (int k = 0; k < W; k++) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            d_v_reg     <= sq_v_reg[W];
            dv_v_reg[0] <= d_v_reg;
            for (int j = 0; j < Q; j++) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
                xd_v_reg[j+1] <= xd_v_reg[j];
            end
            f_v_reg     <= dv_v_reg[Q];
            g_v_reg     <= f_v_reg;
            xd_v_reg[0] <= g_v_reg;
            i_v_reg     <= xd_v_reg[Q];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg.xn <= xs[W-1];
            a_side_reg.yn <= ys[W-1];
            a_side_reg.ax <= xs[W-1] ? (~xs + W'(1)) : xs;
            a_side_reg.ay <= ys[W-1] ? (~ys + W'(1)) : ys;

            b_sqx_reg  <= NW'(a_side_reg.ax) * NW'(a_side_reg.ax);
            b_sqy_reg  <= NW'(a_side_reg.ay) * NW'(a_side_reg.ay);
            b_side_reg <= a_side_reg;

            sq_n_reg[0]    <= b_sqx_reg + b_sqy_reg;
            sq_res_reg[0]  <= '0;
            sq_side_reg[0] <= b_side_reg;
            for (int k = 0; k < W; k++) begin
                sq_n_reg[k+1]    <= sq_n_next[k+1];
                sq_res_reg[k+1]  <= sq_res_next[k+1];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end

            d_ctl_reg.ax   <= sq_side_reg[W].ax;
            d_ctl_reg.ay   <= sq_side_reg[W].ay;
            d_ctl_reg.xn   <= sq_side_reg[W].xn;
            d_ctl_reg.yn   <= sq_side_reg[W].yn;
            d_ctl_reg.mag  <= mag;
            d_ctl_reg.dz   <= CW'(mag) < CW'(dead_reg);
            d_ctl_reg.zero <= (mag == '0);
            d_ctl_reg.sat  <= (mag >= FULL);
            d_ctl_reg.satx <= 1'b0;
            d_ctl_reg.saty <= 1'b0;
            d_diff_reg     <= W'(CW'(mag) - CW'(dead_reg));
            d_den_reg      <= Q'(CW'(FULL) - CW'(dead_reg));

            // (mag - dead) * FULL, FULL being 2^Q - 1
            dv_r_reg[0]   <= (NW'(d_diff_reg) << Q) - NW'(d_diff_reg);
            dv_q_reg[0]   <= '0;
            dv_den_reg[0] <= d_den_reg;
            dv_ctl_reg[0] <= d_ctl_reg;
            for (int j = 0; j < Q; j++) begin
                dv_r_reg[j+1]   <= dv_r_next[j+1];
                dv_q_reg[j+1]   <= dv_q_next[j+1];
                dv_den_reg[j+1] <= dv_den_reg[j];
                dv_ctl_reg[j+1] <= dv_ctl_reg[j];
            end

            f_scaled_reg <= dv_ctl_reg[Q].sat ? FULL[Q-1:0] : dv_q_reg[Q];
            f_ctl_reg    <= dv_ctl_reg[Q];

            g_px_reg  <= NW'(f_ctl_reg.ax) * NW'(f_scaled_reg);
            g_py_reg  <= NW'(f_ctl_reg.ay) * NW'(f_scaled_reg);
            g_ctl_reg <= f_ctl_reg;

            xd_rx_reg[0]  <= g_px_reg;
            xd_ry_reg[0]  <= g_py_reg;
            xd_qx_reg[0]  <= '0;
            xd_qy_reg[0]  <= '0;
            xd_ctl_reg[0] <= g_ctl_sat;
            for (int j = 0; j < Q; j++) begin
                xd_rx_reg[j+1]  <= xd_rx_next[j+1];
                xd_ry_reg[j+1]  <= xd_ry_next[j+1];
                xd_qx_reg[j+1]  <= xd_qx_next[j+1];
                xd_qy_reg[j+1]  <= xd_qy_next[j+1];
                xd_ctl_reg[j+1] <= xd_ctl_reg[j];
            end

            i_dz_reg <= xd_ctl_reg[Q].dz;
            if (xd_ctl_reg[Q].dz || xd_ctl_reg[Q].zero) begin
                i_x_reg <= '0;
                i_y_reg <= '0;
            end else begin
                i_x_reg <= xd_ctl_reg[Q].xn ? (~ext_x + DW'(1)) : ext_x;
                i_y_reg <= xd_ctl_reg[Q].yn ? (~ext_y + DW'(1)) : ext_y;
            end
        end
    end

    // output register and skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg    <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!m_v_reg || m_tready) begin
            if (skid_v_reg) begin
                m_v_reg    <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                m_v_reg <= i_v_reg;
            end
        end else if (i_v_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_v_reg || m_tready) begin
            if (skid_v_reg) begin
                m_x_reg  <= skid_x_reg;
                m_y_reg  <= skid_y_reg;
                m_dz_reg <= skid_dz_reg;
            end else begin
                m_x_reg  <= i_x_reg;
                m_y_reg  <= i_y_reg;
                m_dz_reg <= i_dz_reg;
            end
        end else if (en) begin
            skid_x_reg  <= i_x_reg;
            skid_y_reg  <= i_y_reg;
            skid_dz_reg <= i_dz_reg;
        end
    end

endmodule

// ===== rtl/srdz_checker.sv =====
// Port-level checker for stick_radial_dead_zone, bound to the top level.
// Depends on srdz_pkg (output code limits).
module srdz_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [2*srdz_pkg::DATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_dead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("dead zone word with nonzero axes");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] != srdz_pkg::OUT_NEG_LIMIT
                  && m_tdata[31:16] != srdz_pkg::OUT_NEG_LIMIT)
        else $error("axis outside clamp range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

endmodule

bind stick_radial_dead_zone srdz_checker u_srdz_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/stick_radial_dead_zone_tb.sv =====
// Self-checking testbench for stick_radial_dead_zone: random and edge stick samples,
// random stalls on both streams, checked word by word against an internal predictor.
// Depends on srdz_pkg and rtl/stick_radial_dead_zone.sv.
module stick_radial_dead_zone_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W                = srdz_pkg::DATA_W;
    localparam int DEAD_W                = srdz_pkg::DEAD_W;
    localparam int unsigned DEAD_RESET   = srdz_pkg::DEAD_RESET;

    localparam int SAMPLE_BITS  = 16;
    localparam longint FULL     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam int PIPE_LATENCY = 3 * SAMPLE_BITS + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int NUM_PHASES   = 9;
    localparam int RAND_WORDS   = 150;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic                     in_dead;
    } stick_out_t;

    function automatic longint root_floor(longint n);
        longint r = 0;
        longint trial;
        for (int b = 16; b >= 0; b--) begin
            trial = r | (longint'(1) << b);
            if (trial * trial <= n) r = trial;
        end
        return r;
    endfunction

    class stick_scoreboard;
        int unsigned dead_level;
        stick_out_t  expected_q[$];
        int          errors;
        int          samples;
        int          checked;
        int          dead_hits;

        function new();
            dead_level = DEAD_RESET;
            errors     = 0;
            samples    = 0;
            checked    = 0;
            dead_hits  = 0;
        endfunction

        function logic signed [DATA_W-1:0] shrink_axis(longint a, longint scaled, longint mag);
            longint am = (a < 0) ? -a : a;
            longint q;
            q = am * scaled / mag;
            if (q > FULL) q = FULL;
            return (a < 0) ? DATA_W'(-q) : DATA_W'(q);
        endfunction

        function stick_out_t condition_sample(logic signed [DATA_W-1:0] sx,
                                              logic signed [DATA_W-1:0] sy);
            longint x    = sx;
            longint y    = sy;
            longint dead = dead_level;
            longint mag;
            longint scaled;
            stick_out_t r;
            r   = '0;
            mag = root_floor(x * x + y * y);
            if (mag < dead) begin
                r.in_dead = 1'b1;
                return r;
            end
            if (mag == 0) return r;
            if (dead >= FULL) begin
                scaled = FULL;
            end else begin
                scaled = (mag - dead) * FULL / (FULL - dead);
                if (scaled > FULL) scaled = FULL;
            end
            r.out_x = shrink_axis(x, scaled, mag);
            r.out_y = shrink_axis(y, scaled, mag);
            return r;
        endfunction

        function void note_sample(logic signed [DATA_W-1:0] sx, logic signed [DATA_W-1:0] sy);
            expected_q.push_back(condition_sample(sx, sy));
            samples++;
        endfunction

        function void check_result(logic [2*DATA_W-1:0] tdata, logic tuser);
            stick_out_t exp_w;
            if (expected_q.size() == 0) begin
                $error("unexpected output word: tdata=%h tuser=%b", tdata, tuser);
                errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            checked++;
            if (exp_w.in_dead) dead_hits++;
            if ($signed(tdata[DATA_W-1:0]) != exp_w.out_x) begin
                $error("out_x: expected %0d, actual %0d", exp_w.out_x,
                       $signed(tdata[DATA_W-1:0]));
                errors++;
            end
            if ($signed(tdata[2*DATA_W-1:DATA_W]) != exp_w.out_y) begin
                $error("out_y: expected %0d, actual %0d", exp_w.out_y,
                       $signed(tdata[2*DATA_W-1:DATA_W]));
                errors++;
            end
            if (tuser != exp_w.in_dead) begin
                $error("in_dead_zone: expected %0d, actual %0d", exp_w.in_dead, tuser);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [DEAD_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;

    stick_scoreboard sb;
    bit              idling_on = 1'b1;
    bit              long_hold_req = 1'b0;
    int              hold_left = 0;
    int              cycle_count = 0;
    int              configs_run = 0;

    stick_radial_dead_zone #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // stick_x, stick_y
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_x, out_y
        .m_tuser   (m_tuser)    // in_dead_zone
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    always @(negedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            m_tready  <= 1'b0;
            hold_left = $urandom_range(0, 13);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    task automatic send_word(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(s_tdata[DATA_W-1:0], s_tdata[2*DATA_W-1:DATA_W]);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_dead(int unsigned level);
        cfg_wdata <= DEAD_W'(level);
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.dead_level = level & ((1 << DEAD_W) - 1);
        configs_run++;
    endtask

    // corners, axis extremes and both sides of the dead zone edge
    task automatic send_edges(int unsigned dead);
        int d = int'(dead);
        int diag;
        diag = int'(root_floor(longint'(d) * d / 2));
        send_word(0, 0);
        send_word(16'sh7fff, 0);
        send_word(-16'sh8000, 0);
        send_word(0, 16'sh7fff);
        send_word(0, -16'sh8000);
        send_word(16'sh7fff, 16'sh7fff);
        send_word(-16'sh8000, -16'sh8000);
        send_word(16'sh7fff, -16'sh8000);
        send_word(1, -1);
        send_word(DATA_W'(d), 0);
        if (d > 0) send_word(0, DATA_W'(-(d - 1)));
        send_word(DATA_W'(-diag), DATA_W'(diag));
        send_word(DATA_W'(diag + 1), DATA_W'(-(diag + 1)));
    endtask

    function automatic logic signed [DATA_W-1:0] extreme_axis();
        case ($urandom_range(0, 4))
            0: return -16'sh8000;
            1: return -16'sh7fff;
            2: return 16'sh7fff;
            3: return 0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_random(int unsigned dead);
        int kind;
        longint m;
        longint x;
        longint y;
        kind = $urandom_range(0, 19);
        if (kind < 10) begin
            send_word(DATA_W'($urandom), DATA_W'($urandom));
        end else if (kind < 15) begin
            m = longint'(dead) + $urandom_range(0, 16) - 8;
            if (m < 0) m = 0;
            if (m > FULL) m = FULL;
            x = $urandom_range(0, int'(m));
            y = root_floor(m * m - x * x);
            if ($urandom_range(0, 1)) x = -x;
            if ($urandom_range(0, 1)) y = -y;
            send_word(DATA_W'(x), DATA_W'(y));
        end else if (kind < 17) begin
            send_word(DATA_W'($urandom_range(0, 127) - 64), DATA_W'($urandom_range(0, 127) - 64));
        end else begin
            send_word(extreme_axis(), extreme_axis());
        end
    endtask

    function automatic int unsigned level_for(int phase);
        case (phase)
            1: return 0;
            2: return 32766;
            3: return 32767;
            4: return 1;
            8: return DEAD_RESET;
            default: return $urandom_range(0, 32766);
        endcase
    endfunction

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                write_dead(level_for(p));
            end
            idling_on = (p != NUM_PHASES - 1);
            if (p == 1) long_hold_req = 1'b1;
            send_edges(sb.dead_level);
            repeat (RAND_WORDS) send_random(sb.dead_level);
            s_tvalid <= 1'b0;
        end
        wait_drained();
        $display("Sent %0d stick words over %0d dead zone settings plus the reset value;",
                 sb.samples, configs_run);
        $display("checked %0d output words, %0d of them inside the dead zone.",
                 sb.checked, sb.dead_hits);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== stick_radial_dead_zone.f =====
rtl/srdz_pkg.sv
rtl/stick_radial_dead_zone.sv
rtl/srdz_checker.sv
test/stick_radial_dead_zone_tb.sv
